[hw/rtl/tvrd_pkg.sv]
// ----------------------------------------------------------------------------
// tvrd_pkg
// Shared constants and types for the two-view ray depth triangulation block.
// ----------------------------------------------------------------------------
package tvrd_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_ROT_ROW0    = 3'd0,
		CFG_ROT_ROW1    = 3'd1,
		CFG_ROT_ROW2    = 3'd2,
		CFG_TRANSLATION = 3'd3,
		CFG_DET_THR     = 3'd4,
		CFG_FAR_DEPTH   = 3'd5
	} cfg_idx_t;

	// register reset values
	localparam logic [47:0] ROT_ROW0_RST    = 48'h0000_0000_4000;
	localparam logic [47:0] ROT_ROW1_RST    = 48'h0000_4000_0000;
	localparam logic [47:0] ROT_ROW2_RST    = 48'h4000_0000_0000;
	localparam logic [47:0] TRANSLATION_RST = 48'h0;
	localparam logic [31:0] DET_THR_RST     = 32'd17;
	localparam logic [23:0] FAR_DEPTH_RST   = 24'd256000;

	// depth format and divider
	localparam int QBITS      = 24;
	localparam int DIV_STEPS  = 2;
	localparam logic [23:0] DEPTH_MAX = 24'hFF_FFFF;

	// magnitude and denominator widths into the divider
	localparam int MAG_W = 64;
	localparam int DEN_W = 63;

	// status traveling with an item through the divider
	typedef struct packed {
		logic fail;
		logic sat;
	} flags_t;

endpackage

[hw/rtl/two_view_ray_depth_triangulation.sv]
// ----------------------------------------------------------------------------
// two_view_ray_depth_triangulation
// Least-squares two-view triangulation of reference depth from a ray pair.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one ray pair per transaction, s_tdata holds ref_x,
//   ref_y, cur_x, cur_y (signed Q4.12) from the lowest bit up.
//   Master stream m_*: one result per input transaction, m_tdata holds the
//   unsigned Q16.8 depth, m_tuser[0] is set when the determinant passed the
//   threshold (clear means far_depth was substituted).
//   Config channel cfg_*: cfg_index selects rot_row0..2, translation,
//   det_threshold or far_depth; write only while the stream is drained.
//   Unknown indexes are ignored; cfg_ready is always high.
// Timing:
//   The pipeline has five stages of rotation, dot products and determinant,
//   then the restoring divider with DIV_STEPS quotient bits per stage, then
//   the output register. Throughput is one transaction per cycle unless a
//   held result with m_tready low freezes the pipeline.
// Reset and stall:
//   arst_n clears all valid bits and loads the default registers (identity
//   rotation, zero translation). When m_tready is low with a result held,
//   the whole pipeline freezes and s_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module two_view_ray_depth_triangulation #(
	parameter int DIV_STEPS = tvrd_pkg::DIV_STEPS
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream, tdata: ref_x[15:0], ref_y[31:16], cur_x[47:32], cur_y[63:48]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,
	// master stream, tdata: depth_out[23:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	// master stream, tuser: solved[0]
	output logic [0:0]  m_tuser,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	logic [47:0] rot_row0_q, rot_row1_q, rot_row2_q, translation_q;
	logic [31:0] det_threshold_q;
	logic [23:0] far_depth_q;

	logic        en;
	logic        fr_valid, fr_fail;
	logic [tvrd_pkg::MAG_W-1:0] fr_mag;
	logic [tvrd_pkg::DEN_W-1:0] fr_den;
	logic        dv_valid;
	logic [tvrd_pkg::QBITS-1:0] dv_quo;
	tvrd_pkg::flags_t dv_flags;

	logic        out_vld_q;
	logic [23:0] depth_q;
	logic        solved_q;

	// whole pipeline advances when the output register is free or drained
	assign en        = !out_vld_q || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_row0_q      <= tvrd_pkg::ROT_ROW0_RST;
			rot_row1_q      <= tvrd_pkg::ROT_ROW1_RST;
			rot_row2_q      <= tvrd_pkg::ROT_ROW2_RST;
			translation_q   <= tvrd_pkg::TRANSLATION_RST;
			det_threshold_q <= tvrd_pkg::DET_THR_RST;
			far_depth_q     <= tvrd_pkg::FAR_DEPTH_RST;
		end else if (cfg_valid) begin
			case (tvrd_pkg::cfg_idx_t'(cfg_index))
				tvrd_pkg::CFG_ROT_ROW0:    rot_row0_q      <= cfg_data;
				tvrd_pkg::CFG_ROT_ROW1:    rot_row1_q      <= cfg_data;
				tvrd_pkg::CFG_ROT_ROW2:    rot_row2_q      <= cfg_data;
				tvrd_pkg::CFG_TRANSLATION: translation_q   <= cfg_data;
				tvrd_pkg::CFG_DET_THR:     det_threshold_q <= cfg_data[31:0];
				tvrd_pkg::CFG_FAR_DEPTH:   far_depth_q     <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// arithmetic front end
	tvrd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (s_tvalid),
		.ref_x         (s_tdata[15:0]),
		.ref_y         (s_tdata[31:16]),
		.cur_x         (s_tdata[47:32]),
		.cur_y         (s_tdata[63:48]),
		.rot_row0      (rot_row0_q),
		.rot_row1      (rot_row1_q),
		.rot_row2      (rot_row2_q),
		.translation   (translation_q),
		.det_threshold (det_threshold_q),
		.out_valid     (fr_valid),
		.out_mag       (fr_mag),
		.out_den       (fr_den),
		.out_fail      (fr_fail)
	);

	// depth divider
	tvrd_div #(
		.STEPS (DIV_STEPS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.in_mag    (fr_mag),
		.in_den    (fr_den),
		.in_fail   (fr_fail),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_flags (dv_flags)
	);

	// output register with failure and saturation selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			solved_q <= !dv_flags.fail;
			if (dv_flags.fail) begin
				depth_q <= far_depth_q;
			end else if (dv_flags.sat) begin
				depth_q <= tvrd_pkg::DEPTH_MAX;
			end else begin
				depth_q <= dv_quo;
			end
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = depth_q;
	assign m_tuser[0] = solved_q;

endmodule

[hw/rtl/tvrd_front.sv]
// ----------------------------------------------------------------------------
// tvrd_front
// Five-stage arithmetic front end: ray rotation, normal matrix, determinant,
// numerator magnitude and threshold check.
// ----------------------------------------------------------------------------
module tvrd_front (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [15:0] ref_x,
	input  logic [15:0] ref_y,
	input  logic [15:0] cur_x,
	input  logic [15:0] cur_y,
	input  logic [47:0] rot_row0,
	input  logic [47:0] rot_row1,
	input  logic [47:0] rot_row2,
	input  logic [47:0] translation,
	input  logic [31:0] det_threshold,
	output logic        out_valid,
	output logic [tvrd_pkg::MAG_W-1:0] out_mag,
	output logic [tvrd_pkg::DEN_W-1:0] out_den,
	output logic        out_fail
);

	logic signed [15:0] rot [3][3];
	logic signed [15:0] tv [3];
	logic signed [15:0] fr [3];
	logic signed [33:0] u_d [3];

	// stage registers
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [33:0] u_s1 [3];
	logic signed [15:0] f_s1 [3];
	logic        [63:0] uu_s2 [3];
	logic signed [49:0] uf_s2 [3];
	logic signed [49:0] ut_s2 [3];
	logic signed [31:0] ff_s2 [3];
	logic signed [31:0] ft_s2 [3];
	logic        [31:0] a_s3;
	logic signed [33:0] b_s3;
	logic signed [29:0] c_s3;
	logic signed [37:0] p0_s3;
	logic signed [33:0] p1_s3;
	logic signed [65:0] ac_s4, bb_s4, cp0_s4, bp1_s4;
	logic        [63:0] mag_s5;
	logic        [62:0] den_s5;
	logic               fail_s5;

	// stage 3 combinational sums
	logic        [63:0] asum;
	logic signed [51:0] braw, p0raw;
	logic signed [33:0] craw, p1sum;
	logic signed [51:0] brnd, p0rnd;
	logic signed [33:0] crnd;

	// stage 5 combinational
	logic signed [65:0] det, nfull, thr;
	logic        [63:0] n64;

	// unpack rotation, translation and rays
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			rot[0][j] = rot_row0[16*j +: 16];
			rot[1][j] = rot_row1[16*j +: 16];
			rot[2][j] = rot_row2[16*j +: 16];
			tv[j]     = translation[16*j +: 16];
		end
		fr[0] = ref_x;
		fr[1] = ref_y;
		fr[2] = 16'sd4096;
	end

	// rotated reference ray at Q26
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			u_d[i] = 34'(rot[i][0]) * 34'(fr[0]) + 34'(rot[i][1]) * 34'(fr[1])
				+ 34'(rot[i][2]) * 34'(fr[2]);
		end
	end

	// stage 1: rotation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1    <= u_d;
			f_s1[0] <= cur_x;
			f_s1[1] <= cur_y;
			f_s1[2] <= 16'sd4096;
		end
	end

	// stage 2: element products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				uu_s2[i] <= 64'(68'(u_s1[i]) * 68'(u_s1[i]));
				uf_s2[i] <= 50'(u_s1[i]) * 50'(f_s1[i]);
				ut_s2[i] <= 50'(u_s1[i]) * 50'(tv[i]);
				ff_s2[i] <= 32'(f_s1[i]) * 32'(f_s1[i]);
				ft_s2[i] <= 32'(f_s1[i]) * 32'(tv[i]);
			end
		end
	end

	// stage 3: dot products rounded to Q20, half up
	always_comb begin
		asum  = uu_s2[0] + uu_s2[1] + uu_s2[2] + 64'h8000_0000;
		braw  = 52'(uf_s2[0]) + 52'(uf_s2[1]) + 52'(uf_s2[2]);
		p0raw = 52'(ut_s2[0]) + 52'(ut_s2[1]) + 52'(ut_s2[2]);
		craw  = 34'(ff_s2[0]) + 34'(ff_s2[1]) + 34'(ff_s2[2]);
		p1sum = 34'(ft_s2[0]) + 34'(ft_s2[1]) + 34'(ft_s2[2]);
		brnd  = braw + 52'sd131072;
		p0rnd = p0raw + 52'sd8192;
		crnd  = craw + 34'sd8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3  <= asum[63:32];
			b_s3  <= brnd[51:18];
			c_s3  <= crnd[33:4];
			p0_s3 <= p0rnd[51:14];
			p1_s3 <= p1sum;
		end
	end

	// stage 4: determinant and numerator products at Q40
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ac_s4  <= 66'($signed({1'b0, a_s3})) * 66'(c_s3);
			bb_s4  <= 66'(b_s3) * 66'(b_s3);
			cp0_s4 <= 66'(c_s3) * 66'(p0_s3);
			bp1_s4 <= 66'(b_s3) * 66'(p1_s3);
		end
	end

	// stage 5: determinant check and numerator magnitude
	always_comb begin
		det   = ac_s4 - bb_s4;
		nfull = cp0_s4 - bp1_s4;
		n64   = nfull[63:0];
		thr   = $signed({18'd0, det_threshold, 16'd0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fail_s5 <= det[65] || (det == 66'sd0) || (det < thr);
			mag_s5  <= n64[63] ? (64'd0 - n64) : n64;
			den_s5  <= det[62:0];
		end
	end

	assign out_valid = v_s5;
	assign out_mag   = mag_s5;
	assign out_den   = den_s5;
	assign out_fail  = fail_s5;

endmodule

[hw/rtl/tvrd_div.sv]
// ----------------------------------------------------------------------------
// tvrd_div
// Pipelined restoring divider: floor(mag * 256 / den) as an unsigned Q16.8
// quotient, with an overflow flag when the integer part reaches 65536.
// ----------------------------------------------------------------------------
module tvrd_div #(
	parameter int STEPS = tvrd_pkg::DIV_STEPS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [tvrd_pkg::MAG_W-1:0] in_mag,
	input  logic [tvrd_pkg::DEN_W-1:0] in_den,
	input  logic                       in_fail,
	output logic                       out_valid,
	output logic [tvrd_pkg::QBITS-1:0] out_quo,
	output tvrd_pkg::flags_t           out_flags
);

	localparam int QB   = tvrd_pkg::QBITS;
	localparam int DW   = tvrd_pkg::DEN_W;
	localparam int MW   = tvrd_pkg::MAG_W;
	localparam int NSTG = QB / STEPS;
	// dividend bits below the first partial remainder, plus fraction bits
	localparam int LOW_W = QB;
	localparam int HI_SH = QB - 8;

	logic                 v_s   [NSTG];
	logic [DW-1:0]        rem_s [NSTG];
	logic [LOW_W-1:0]     low_s [NSTG];
	logic [QB-1:0]        quo_s [NSTG];
	logic [DW-1:0]        den_s [NSTG];
	tvrd_pkg::flags_t     fl_s  [NSTG];

	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		logic             v_in;
		logic [DW-1:0]    rem_in, den_in;
		logic [LOW_W-1:0] low_in;
		logic [QB-1:0]    quo_in;
		tvrd_pkg::flags_t fl_in;
		logic [DW-1:0]    rem_d;
		logic [LOW_W-1:0] low_d;
		logic [QB-1:0]    quo_d;
		logic [DW:0]      trial;

		// stage inputs: first stage seeds the remainder and overflow check
		if (k == 0) begin : g_first
			always_comb begin
				v_in      = in_valid;
				rem_in    = DW'(in_mag[MW-1:HI_SH]);
				low_in    = {in_mag[HI_SH-1:0], 8'd0};
				quo_in    = '0;
				den_in    = in_den;
				fl_in.fail = in_fail;
				fl_in.sat  = (DW'(in_mag[MW-1:HI_SH]) >= in_den);
			end
		end else begin : g_next
			always_comb begin
				v_in   = v_s[k-1];
				rem_in = rem_s[k-1];
				low_in = low_s[k-1];
				quo_in = quo_s[k-1];
				den_in = den_s[k-1];
				fl_in  = fl_s[k-1];
			end
		end

		// restoring division steps
		always_comb begin
			rem_d = rem_in;
			low_d = low_in;
			quo_d = quo_in;
			trial = '0;
			for (int j = 0; j < STEPS; j++) begin
				trial = {rem_d, low_d[LOW_W-1]};
				low_d = {low_d[LOW_W-2:0], 1'b0};
				if (trial >= {1'b0, den_in}) begin
					rem_d = DW'(trial - {1'b0, den_in});
					quo_d = {quo_d[QB-2:0], 1'b1};
				end else begin
					rem_d = trial[DW-1:0];
					quo_d = {quo_d[QB-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_d;
				low_s[k] <= low_d;
				quo_s[k] <= quo_d;
				den_s[k] <= den_in;
				fl_s[k]  <= fl_in;
			end
		end
	end

	assign out_valid = v_s[NSTG-1];
	assign out_quo   = quo_s[NSTG-1];
	assign out_flags = fl_s[NSTG-1];

endmodule

[tb/tvrd_depth_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvrd_depth_checker
// Passive checker for the two-view ray depth triangulation block: mirrors the
// configuration writes, computes the expected depth and solved flag of every
// accepted ray pair and compares them in order with the master stream.
// ----------------------------------------------------------------------------
module tvrd_depth_checker
	import tvrd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic [0:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	output int          errors,
	output int          pending
);

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic [23:0] depth;
		logic        solved;
	} depth_res_t;

	// mirrored registers
	logic [47:0] rot_q [3];
	logic [47:0] trans_q;
	logic [31:0] thr_q;
	logic [23:0] far_q;

	depth_res_t depth_fifo [$];

	function automatic wide_t lane16(logic [47:0] word, int k);
		wide_t v;
		v = $signed(word[16*k +: 16]);
		return v;
	endfunction

	// expected result of one ray pair under the mirrored setting
	function automatic depth_res_t triangulate(logic [63:0] rays);
		wide_t fr [3];
		wide_t f [3];
		wide_t u [3];
		wide_t asum, braw, craw, p0raw, p1;
		wide_t a, b, c, p0, det, thr, n, mag, q;
		depth_res_t res;
		fr[0] = $signed(rays[15:0]);
		fr[1] = $signed(rays[31:16]);
		fr[2] = 4096;
		f[0] = $signed(rays[47:32]);
		f[1] = $signed(rays[63:48]);
		f[2] = 4096;
		asum = 0; braw = 0; craw = 0; p0raw = 0; p1 = 0;
		for (int i = 0; i < 3; i++) begin
			u[i] = 0;
			for (int j = 0; j < 3; j++)
				u[i] += lane16(rot_q[i], j) * fr[j];
		end
		for (int i = 0; i < 3; i++) begin
			asum  += u[i] * u[i];
			braw  += u[i] * f[i];
			craw  += f[i] * f[i];
			p0raw += u[i] * lane16(trans_q, i);
			p1    += f[i] * lane16(trans_q, i);
		end
		// round half up to q20
		a  = (asum + (wide_t'(1) <<< 31)) >>> 32;
		b  = (braw + (wide_t'(1) <<< 17)) >>> 18;
		c  = (craw + 8) >>> 4;
		p0 = (p0raw + (wide_t'(1) <<< 13)) >>> 14;
		det = a * c - b * b;
		thr = wide_t'({96'd0, thr_q}) <<< 16;
		if (det <= 0 || det < thr) begin
			res.depth  = far_q;
			res.solved = 1'b0;
			return res;
		end
		n   = c * p0 - b * p1;
		mag = (n < 0) ? -n : n;
		q   = (mag <<< 8) / det;
		res.depth  = (q >= (wide_t'(1) <<< 24)) ? DEPTH_MAX : q[23:0];
		res.solved = 1'b1;
		return res;
	endfunction

	// register mirror
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= ROT_ROW0_RST;
			rot_q[1] <= ROT_ROW1_RST;
			rot_q[2] <= ROT_ROW2_RST;
			trans_q  <= TRANSLATION_RST;
			thr_q    <= DET_THR_RST;
			far_q    <= FAR_DEPTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROT_ROW0:    rot_q[0] <= cfg_data;
				CFG_ROT_ROW1:    rot_q[1] <= cfg_data;
				CFG_ROT_ROW2:    rot_q[2] <= cfg_data;
				CFG_TRANSLATION: trans_q  <= cfg_data;
				CFG_DET_THR:     thr_q    <= cfg_data[31:0];
				CFG_FAR_DEPTH:   far_q    <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		depth_res_t want;
		if (!arst_n) begin
			errors = 0;
			depth_fifo.delete();
			pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				depth_fifo.insert(depth_fifo.size(), triangulate(s_tdata));
			if (m_tvalid && m_tready) begin
				if (depth_fifo.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result depth=%0d solved=%0d",
							m_tdata, m_tuser[0]);
				end else begin
					want = depth_fifo.pop_front();
					if (want.depth !== m_tdata || want.solved !== m_tuser[0]) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected depth=%0d solved=%0d, got depth=%0d solved=%0d",
								want.depth, want.solved, m_tdata, m_tuser[0]);
					end
				end
			end
			pending = depth_fifo.size();
		end
	end

endmodule

[tb/two_view_ray_depth_triangulation_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_view_ray_depth_triangulation_tb
// Drives ray pairs and configuration writes into the triangulation block
// under several register settings and idle patterns, including a long output
// hold-off; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module two_view_ray_depth_triangulation_tb;
	import tvrd_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;
	int          errors;
	int          pending;

	// 0 none, 1 sender idles, 2 receiver stalls, 3 both
	int          idle_mode;
	int          hold_req;
	int          hold_done;
	int          hold_left;
	int          cycles;

	two_view_ray_depth_triangulation dut (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	tvrd_depth_checker u_checker (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.errors, .pending
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("two_view_ray_depth_triangulation regression: fail");
			$finish;
		end
	end

	// receiver ready, with a counted hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_done != hold_req) begin
			m_tready <= 1'b0;
			hold_left <= 400;
			hold_done <= hold_done + 1;
		end else if (idle_mode == 2) begin
			m_tready <= ($urandom_range(99) >= 57);
		end else if (idle_mode == 3) begin
			m_tready <= ($urandom_range(99) >= 16);
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic int sender_idle_pct();
		return (idle_mode == 1) ? 57 : (idle_mode == 3) ? 16 : 0;
	endfunction

	// one ray pair transaction, valid stays high into the next one
	task automatic send_rays(logic [15:0] rx, logic [15:0] ry, logic [15:0] cx,
			logic [15:0] cy);
		while ($urandom_range(99) < sender_idle_pct()) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {cy, cx, ry, rx};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [47:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// let the pipeline drain before touching registers
	task automatic drain();
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic load_setting(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
			logic [47:0] t, logic [31:0] thr, logic [23:0] far);
		drain();
		write_reg(CFG_ROT_ROW0, r0);
		write_reg(CFG_ROT_ROW1, r1);
		write_reg(CFG_ROT_ROW2, r2);
		write_reg(CFG_TRANSLATION, t);
		write_reg(CFG_DET_THR, thr);
		write_reg(CFG_FAR_DEPTH, far);
	endtask

	function automatic logic [15:0] near_identity(int diag);
		return diag ? 16'(16384 + $signed($urandom_range(2000)) - 1000)
			: 16'($signed($urandom_range(3000)) - 1500);
	endfunction

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	// random pairs: mostly plausible rays with small disparity, some noise
	task automatic random_rays(int count);
		logic [15:0] rx, ry, cx, cy;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) < 7) begin
				rx = 16'($signed($urandom_range(8191)) - 4096);
				ry = 16'($signed($urandom_range(8191)) - 4096);
				cx = rx + 16'($signed($urandom_range(600)) - 300);
				cy = ry + 16'($signed($urandom_range(60)) - 30);
			end else begin
				rx = 16'($urandom()); ry = 16'($urandom());
				cx = 16'($urandom()); cy = 16'($urandom());
			end
			send_rays(rx, ry, cx, cy);
		end
	endtask

	initial begin
		logic [47:0] r0, r1, r2;
		cycles = 0;
		idle_mode = 0;
		hold_req = 0;
		hold_done = 0;
		hold_left = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset setting: zero translation, so depth is zero or far
		send_rays(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_rays(16'h1000, 16'h0000, 16'h0000, 16'h0000);

		// baseline, translation along x
		load_setting(ROT_ROW0_RST, ROT_ROW1_RST, ROT_ROW2_RST, 48'h0000_0000_0100,
			DET_THR_RST, FAR_DEPTH_RST);
		send_rays(16'h0000, 16'h0000, 16'h0000, 16'h0000); // parallel rays
		send_rays(16'h0000, 16'h0000, 16'h0100, 16'h0000);
		send_rays(16'h0000, 16'h0000, 16'h0001, 16'h0000); // det rounds to zero
		send_rays(16'h0800, 16'hF800, 16'h0900, 16'hF800);
		send_rays(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
		send_rays(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
		send_rays(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8001);
		send_rays(16'hFFFF, 16'h0001, 16'h0000, 16'h0000);
		send_rays(16'h1000, 16'h1000, 16'h1010, 16'h1000);

		// extreme registers: zero threshold, full scale translation
		load_setting(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h8000_7FFF_8000,
			48'h7FFF_8000_7FFF, 32'd0, 24'hFF_FFFF);
		send_rays(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		send_rays(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_rays(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_rays(16'h0000, 16'h0000, 16'h0000, 16'h0000); // zero rays, zero thr
		random_rays(30);

		// threshold at maximum, far depth zero
		load_setting(ROT_ROW0_RST, ROT_ROW1_RST, ROT_ROW2_RST, 48'hFFFF_FFFF_FFFF,
			32'hFFFF_FFFF, 24'd0);
		send_rays(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		random_rays(20);

		// random settings across the idle patterns
		for (int ph = 0; ph < 8; ph++) begin
			r0 = {near_identity(0), near_identity(0), near_identity(1)};
			r1 = {near_identity(0), near_identity(1), near_identity(0)};
			r2 = {near_identity(1), near_identity(0), near_identity(0)};
			if (ph == 5) begin
				r0 = rand48(); r1 = rand48(); r2 = rand48();
			end
			load_setting(r0, r1, r2,
				{16'($signed($urandom_range(512)) - 256),
				 16'($signed($urandom_range(512)) - 256),
				 16'($signed($urandom_range(2048)) - 1024)},
				(ph == 6) ? $urandom() : $urandom_range(4096),
				24'($urandom_range(24'hFF_FFFF)));
			idle_mode = ph % 4;
			random_rays(150);
		end

		// pressure: receiver holds off while the sender keeps offering
		idle_mode = 0;
		hold_req = hold_req + 1;
		random_rays(120);

		drain();
		if (errors == 0)
			$display("two_view_ray_depth_triangulation regression: pass");
		else
			$display("two_view_ray_depth_triangulation regression: fail");
		$finish;
	end

endmodule

[files.f]
hw/rtl/tvrd_pkg.sv
hw/rtl/tvrd_front.sv
hw/rtl/tvrd_div.sv
hw/rtl/two_view_ray_depth_triangulation.sv
tb/tvrd_depth_checker.sv
tb/two_view_ray_depth_triangulation_tb.sv
